// ----- rtl/core/rsc_pkg.sv -----
// Shared constants, types and helper functions for the Rabbit stream cipher block.
`default_nettype none

package rsc_pkg;

  // Word geometry
  localparam int WORD_W    = 32;
  localparam int KEY_W     = 64;
  localparam int NUM_WORDS = 8;
  localparam int IDX_W     = 3;
  localparam int BLK_WORDS = 4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

  // Round sequencing: counter word update, sum, square, g-value, one word per cycle
  localparam int U_OFS    = 1;
  localparam int SQ_OFS   = 2;
  localparam int G_OFS    = 3;
  localparam int CNT_W    = 4;
  localparam int CNT_LAST = NUM_WORDS + G_OFS - 1;

  // Key setup runs this many rounds before the counter mix
  localparam int SETUP_ROUNDS = 4;
  localparam int RND_W        = 2;

  // Counter increment constants
  localparam logic [WORD_W-1:0] CTR_CONST [NUM_WORDS] = '{
    32'h4d34d34d, 32'hd34d34d3, 32'h34d34d34, 32'h4d34d34d,
    32'hd34d34d3, 32'h34d34d34, 32'h4d34d34d, 32'hd34d34d3
  };

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic             in_load;
    logic             load_key;
    logic             ctr_en;
    logic [IDX_W-1:0] ctr_idx;
    logic             u_en;
    logic             sq_en;
    logic             g_en;
    logic             mix_en;
    logic             kmix_en;
    logic             out_load;
  } dp_cmd_t;

  function automatic logic [WORD_W-1:0] rotl16(input logic [WORD_W-1:0] v);
    rotl16 = {v[15:0], v[31:16]};
  endfunction

  function automatic logic [WORD_W-1:0] rotl8(input logic [WORD_W-1:0] v);
    rotl8 = {v[23:0], v[31:24]};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rsc_ifs.sv -----
// Channel interfaces of the Rabbit stream cipher block: data in, data out, configuration.
`default_nettype none

interface rsc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       restart;
  logic [rsc_pkg::WORD_W-1:0] data_word0;
  logic [rsc_pkg::WORD_W-1:0] data_word1;
  logic [rsc_pkg::WORD_W-1:0] data_word2;
  logic [rsc_pkg::WORD_W-1:0] data_word3;

  modport source (output valid, output restart, output data_word0, output data_word1,
                  output data_word2, output data_word3, input ready);
  modport sink (input valid, input restart, input data_word0, input data_word1,
                input data_word2, input data_word3, output ready);
endinterface

interface rsc_out_if;
  logic                       valid;
  logic                       ready;
  logic [rsc_pkg::WORD_W-1:0] out_word0;
  logic [rsc_pkg::WORD_W-1:0] out_word1;
  logic [rsc_pkg::WORD_W-1:0] out_word2;
  logic [rsc_pkg::WORD_W-1:0] out_word3;

  modport source (output valid, output out_word0, output out_word1, output out_word2,
                  output out_word3, input ready);
  modport sink (input valid, input out_word0, input out_word1, input out_word2,
                input out_word3, output ready);
endinterface

interface rsc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [rsc_pkg::CFG_IDX_W-1:0] index;
  logic [rsc_pkg::KEY_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/rsc_datapath.sv -----
// Datapath of the Rabbit stream cipher: key registers, cipher state, g-function unit, output.
`default_nettype none

module rsc_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire rsc_pkg::dp_cmd_t            cmd,
  input  wire logic                        cfg_wr,
  input  wire logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rsc_pkg::KEY_W-1:0]   cfg_data,
  input  wire logic [rsc_pkg::WORD_W-1:0]  data_word0,
  input  wire logic [rsc_pkg::WORD_W-1:0]  data_word1,
  input  wire logic [rsc_pkg::WORD_W-1:0]  data_word2,
  input  wire logic [rsc_pkg::WORD_W-1:0]  data_word3,
  output logic      [rsc_pkg::WORD_W-1:0]  out_word0,
  output logic      [rsc_pkg::WORD_W-1:0]  out_word1,
  output logic      [rsc_pkg::WORD_W-1:0]  out_word2,
  output logic      [rsc_pkg::WORD_W-1:0]  out_word3
);

  localparam int W = rsc_pkg::WORD_W;
  localparam int N = rsc_pkg::NUM_WORDS;

  logic [rsc_pkg::KEY_W-1:0] key_low_r, key_high_r;
  logic [W-1:0] x_r   [N];
  logic [W-1:0] x_nxt [N];
  logic [W-1:0] c_r   [N];
  logic [W-1:0] c_nxt [N];
  logic         carry_r, carry_nxt;
  logic [W-1:0] g_r [N];
  logic [W-1:0] u_r;
  logic [2*W-1:0] sq_r;
  logic [W-1:0] data_r [rsc_pkg::BLK_WORDS];
  logic [W-1:0] out_r  [rsc_pkg::BLK_WORDS];

  logic [W-1:0] k0, k1, k2, k3;
  logic [W:0]   ctr_sum;
  logic [W-1:0] mix [N];
  logic [W-1:0] ks  [rsc_pkg::BLK_WORDS];

  assign k0 = key_low_r[W-1:0];
  assign k1 = key_low_r[2*W-1:W];
  assign k2 = key_high_r[W-1:0];
  assign k3 = key_high_r[2*W-1:W];

  // Key registers take configuration transfers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r  <= '0;
      key_high_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_index == rsc_pkg::REG_KEY_LOW) key_low_r <= cfg_data;
      if (cfg_index == rsc_pkg::REG_KEY_HIGH) key_high_r <= cfg_data;
    end
  end

  // Counter word at the head of the ring plus its constant and the chained carry
  assign ctr_sum = {1'b0, c_r[0]} + {1'b0, rsc_pkg::CTR_CONST[cmd.ctr_idx]} +
                   {{W{1'b0}}, carry_r};

  // Mixing of the g-values into the new state words
  always_comb begin
    for (int j = 0; j < N; j++) begin
      if ((j % 2) == 0) begin
        mix[j] = g_r[j] + rsc_pkg::rotl16(g_r[(j + N - 1) % N]) +
                 rsc_pkg::rotl16(g_r[(j + N - 2) % N]);
      end else begin
        mix[j] = g_r[j] + rsc_pkg::rotl8(g_r[(j + N - 1) % N]) + g_r[(j + N - 2) % N];
      end
    end
  end

  // Next state and counters
  always_comb begin
    x_nxt     = x_r;
    c_nxt     = c_r;
    carry_nxt = carry_r;
    priority if (cmd.load_key) begin
      x_nxt[0] = k0;
      x_nxt[2] = k1;
      x_nxt[4] = k2;
      x_nxt[6] = k3;
      x_nxt[1] = {k3[15:0], k2[31:16]};
      x_nxt[3] = {k0[15:0], k3[31:16]};
      x_nxt[5] = {k1[15:0], k0[31:16]};
      x_nxt[7] = {k2[15:0], k1[31:16]};
      c_nxt[0] = rsc_pkg::rotl16(k2);
      c_nxt[2] = rsc_pkg::rotl16(k3);
      c_nxt[4] = rsc_pkg::rotl16(k0);
      c_nxt[6] = rsc_pkg::rotl16(k1);
      c_nxt[1] = {k0[31:16], k1[15:0]};
      c_nxt[3] = {k1[31:16], k2[15:0]};
      c_nxt[5] = {k2[31:16], k3[15:0]};
      c_nxt[7] = {k3[31:16], k0[15:0]};
      carry_nxt = 1'b0;
    end else if (cmd.kmix_en) begin
      for (int i = 0; i < N; i++) c_nxt[(i + N / 2) % N] = c_r[(i + N / 2) % N] ^ x_r[i];
    end else if (cmd.mix_en) begin
      x_nxt = mix;
    end else begin
      // Counter ring: the updated word drops in at the tail
      if (cmd.ctr_en) begin
        for (int i = 0; i < N - 1; i++) c_nxt[i] = c_r[i + 1];
        c_nxt[N-1] = ctr_sum[W-1:0];
        carry_nxt  = ctr_sum[W];
      end
      // State ring turns in step with the sum stage
      if (cmd.u_en) begin
        for (int i = 0; i < N - 1; i++) x_nxt[i] = x_r[i + 1];
        x_nxt[N-1] = x_r[0];
      end
    end
  end

  // Cipher state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        x_r[i] <= '0;
        c_r[i] <= '0;
      end
      carry_r <= 1'b0;
    end else begin
      x_r     <= x_nxt;
      c_r     <= c_nxt;
      carry_r <= carry_nxt;
    end
  end

  // g-function pipe: sum, square, fold; g-values shift in at the tail
  always_ff @(posedge clk) begin
    if (cmd.u_en) u_r <= x_r[0] + c_r[N-1];
    if (cmd.sq_en) sq_r <= u_r * u_r;
    if (cmd.g_en) begin
      for (int i = 0; i < N - 1; i++) g_r[i] <= g_r[i + 1];
      g_r[N-1] <= sq_r[2*W-1:W] ^ sq_r[W-1:0];
    end
  end

  // Keystream words from the current state
  assign ks[0] = x_r[0] ^ {16'h0, x_r[5][31:16]} ^ {x_r[3][15:0], 16'h0};
  assign ks[1] = x_r[2] ^ {16'h0, x_r[7][31:16]} ^ {x_r[5][15:0], 16'h0};
  assign ks[2] = x_r[4] ^ {16'h0, x_r[1][31:16]} ^ {x_r[7][15:0], 16'h0};
  assign ks[3] = x_r[6] ^ {16'h0, x_r[3][31:16]} ^ {x_r[1][15:0], 16'h0};

  // Hold the accepted block, then load the result register
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      data_r[0] <= data_word0;
      data_r[1] <= data_word1;
      data_r[2] <= data_word2;
      data_r[3] <= data_word3;
    end
    if (cmd.out_load) begin
      for (int i = 0; i < rsc_pkg::BLK_WORDS; i++) out_r[i] <= data_r[i] ^ ks[i];
    end
  end

  assign out_word0 = out_r[0];
  assign out_word1 = out_r[1];
  assign out_word2 = out_r[2];
  assign out_word3 = out_r[3];

endmodule

`default_nettype wire

// ----- rtl/core/rsc_ctrl.sv -----
// Sequencer of the Rabbit stream cipher: key setup, rounds and result handoff.
`default_nettype none

module rsc_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_restart,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output rsc_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_MIX,
    ST_KMIX,
    ST_FINISH
  } state_t;

  localparam logic [rsc_pkg::CNT_W-1:0] CNT_LAST = rsc_pkg::CNT_W'(rsc_pkg::CNT_LAST);
  localparam logic [rsc_pkg::CNT_W-1:0] CTR_END  =
    rsc_pkg::CNT_W'(rsc_pkg::NUM_WORDS - 1);
  localparam logic [rsc_pkg::CNT_W-1:0] U_FIRST  = rsc_pkg::CNT_W'(rsc_pkg::U_OFS);
  localparam logic [rsc_pkg::CNT_W-1:0] SQ_FIRST = rsc_pkg::CNT_W'(rsc_pkg::SQ_OFS);
  localparam logic [rsc_pkg::CNT_W-1:0] G_FIRST  = rsc_pkg::CNT_W'(rsc_pkg::G_OFS);

  state_t                      state_r, state_nxt;
  logic [rsc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [rsc_pkg::RND_W-1:0]   rounds_r, rounds_nxt;
  logic                        setup_r, setup_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // Datapath commands decoded from state and round cycle
  always_comb begin
    cmd          = '0;
    cmd.in_load  = in_xfer;
    cmd.load_key = (state_r == ST_LOAD);
    cmd.ctr_en   = (state_r == ST_ROUND) && (cnt_r <= CTR_END);
    cmd.ctr_idx  = cnt_r[rsc_pkg::IDX_W-1:0];
    cmd.u_en     = (state_r == ST_ROUND) && (cnt_r >= U_FIRST) &&
                   (cnt_r <= CTR_END + U_FIRST);
    cmd.sq_en    = (state_r == ST_ROUND) && (cnt_r >= SQ_FIRST) &&
                   (cnt_r <= CTR_END + SQ_FIRST);
    cmd.g_en     = (state_r == ST_ROUND) && (cnt_r >= G_FIRST);
    cmd.mix_en   = (state_r == ST_MIX);
    cmd.kmix_en  = (state_r == ST_KMIX);
    cmd.out_load = (state_r == ST_FINISH) && (!out_valid_r || out_ready);
  end

  // Next-state logic
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    rounds_nxt = rounds_r;
    setup_nxt  = setup_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cnt_nxt = '0;
          if (in_restart) begin
            state_nxt  = ST_LOAD;
            rounds_nxt = rsc_pkg::RND_W'(rsc_pkg::SETUP_ROUNDS - 1);
            setup_nxt  = 1'b1;
          end else begin
            state_nxt  = ST_ROUND;
            rounds_nxt = '0;
            setup_nxt  = 1'b0;
          end
        end
      end
      ST_LOAD: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_MIX;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_MIX: begin
        if (rounds_r != '0) begin
          state_nxt  = ST_ROUND;
          rounds_nxt = rounds_r - 1'b1;
        end else if (setup_r) begin
          state_nxt = ST_KMIX;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_KMIX: begin
        state_nxt = ST_ROUND;
        setup_nxt = 1'b0;
      end
      ST_FINISH: begin
        if (cmd.out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid: set on load, drop on transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      rounds_r    <= '0;
      setup_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rounds_r    <= rounds_nxt;
      setup_r     <= setup_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A block in work closes the input until its result is loaded
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input accepted while a block was in work");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  // Loading a result makes it visible on the next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("loaded result not presented");

  // Whole-state commands never collide
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_key, cmd.mix_en, cmd.kmix_en, cmd.ctr_en, cmd.out_load}))
    else $error("conflicting datapath commands");

endmodule

`default_nettype wire

// ----- rtl/core/rabbit_stream_cipher.sv -----
// Top level of the Rabbit stream cipher: sequencer plus datapath on three channels.
//
// Use: write the 128-bit key through the configuration channel (index 0 = key bytes
// 0..7, index 1 = key bytes 8..15) while the block is idle; cfg_ch.ready is always
// high. Each transfer on in_ch carries one 16-byte block as four little-endian words;
// with restart set, key setup from the key registers runs first. Each block gives one
// transfer on out_ch: the data words XOR the keystream, which encrypts or decrypts.
// Each round: the counter chain, sum, square and fold run one word per cycle through a
// single 32x32 multiplier, then the state is mixed. Key setup adds a load step, four
// rounds and a counter mix. One block is in work at a time; the next is taken once the
// previous result sits in the output register, so a new block may start while out_ch
// stalls. A result waiting on out_ch holds its words; the block then waits to load its
// next result until that transfer happens.
// Reset (rst_n low at a clock edge) clears the key, the state words, the counters and
// the carry, and empties the output register.
`default_nettype none

module rabbit_stream_cipher (
  input  wire logic clk,
  input  wire logic rst_n,
  rsc_in_if.sink    in_ch,
  rsc_out_if.source out_ch,
  rsc_cfg_if.sink   cfg_ch
);

  rsc_pkg::dp_cmd_t cmd;

  // Configuration writes are always taken
  assign cfg_ch.ready = 1'b1;

  rsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_restart (in_ch.restart),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .cmd        (cmd)
  );

  rsc_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg_wr     (cfg_ch.valid),
    .cfg_index  (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .data_word0 (in_ch.data_word0),
    .data_word1 (in_ch.data_word1),
    .data_word2 (in_ch.data_word2),
    .data_word3 (in_ch.data_word3),
    .out_word0  (out_ch.out_word0),
    .out_word1  (out_ch.out_word1),
    .out_word2  (out_ch.out_word2),
    .out_word3  (out_ch.out_word3)
  );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// Self-checking testbench for the Rabbit stream cipher: table-driven and random blocks.
`default_nettype none

module testbench;

  localparam int WORD_W       = rsc_pkg::WORD_W;
  localparam int KEY_W        = rsc_pkg::KEY_W;
  localparam int NUM_WORDS    = rsc_pkg::NUM_WORDS;
  localparam int BLK_WORDS    = rsc_pkg::BLK_WORDS;
  localparam int CFG_IDX_W    = rsc_pkg::CFG_IDX_W;
  localparam int SETUP_ROUNDS = rsc_pkg::SETUP_ROUNDS;

  typedef logic [BLK_WORDS-1:0][WORD_W-1:0] block_t;

  // Table row kinds: cipher block, key load, write to an unused register index
  typedef enum logic [1:0] {ROW_BLOCK, ROW_KEY, ROW_SPARE_WRITE} row_kind_t;

  // Data words listed word3 first; for a key row the upper half is key_high
  typedef struct packed {
    row_kind_t kind;
    logic      restart;
    block_t    words;
  } stim_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  localparam int NUM_ROWS         = 22;
  localparam int NUM_PHASES       = 12;
  localparam int BLOCKS_PER_PHASE = 161;
  localparam int MAX_WAIT         = 8;
  localparam int TAIL_CYCLES      = 100;
  localparam int QUIET_LIMIT      = 2000;

  // Counter increments of the round function
  localparam logic [WORD_W-1:0] RATE_WORD [NUM_WORDS] = '{
    32'h4d34d34d, 32'hd34d34d3, 32'h34d34d34, 32'h4d34d34d,
    32'hd34d34d3, 32'h34d34d34, 32'h4d34d34d, 32'hd34d34d3
  };

  localparam stim_row_t STIM_TABLE [NUM_ROWS] = '{
    // running from the cleared state, no key setup yet
    '{ROW_BLOCK,       1'b0, 128'h00000000_00000000_00000000_00000000},
    '{ROW_BLOCK,       1'b0, 128'hffffffff_ffffffff_ffffffff_ffffffff},
    '{ROW_BLOCK,       1'b0, 128'ha5a5a5a5_5a5a5a5a_a5a5a5a5_5a5a5a5a},
    // key setup from the zero key registers
    '{ROW_BLOCK,       1'b1, 128'h00000000_00000000_00000000_00000000},
    '{ROW_BLOCK,       1'b0, 128'hffffffff_ffffffff_ffffffff_ffffffff},
    // new key must not act before the next restart
    '{ROW_KEY,         1'b0, 128'hffffffff_ffffffff_ffffffff_ffffffff},
    '{ROW_BLOCK,       1'b0, 128'h00000000_00000000_00000000_00000000},
    '{ROW_BLOCK,       1'b1, 128'h00000000_00000000_00000000_00000000},
    '{ROW_BLOCK,       1'b0, 128'h00000000_00000000_00000000_00000000},
    // writes to unused indexes leave the key alone
    '{ROW_SPARE_WRITE, 1'b0, 128'h01234567_89abcdef_01234567_89abcdef},
    '{ROW_BLOCK,       1'b1, 128'h00000000_00000000_00000000_00000000},
    '{ROW_BLOCK,       1'b1, 128'hffffffff_ffffffff_ffffffff_ffffffff},
    '{ROW_KEY,         1'b0, 128'hfedcba98_76543210_01234567_89abcdef},
    '{ROW_BLOCK,       1'b1, 128'h80000000_7fffffff_00000001_fffffffe},
    '{ROW_BLOCK,       1'b0, 128'h00000001_80000000_fffffffe_7fffffff},
    '{ROW_BLOCK,       1'b0, 128'h00000000_00000000_00000000_00000000},
    '{ROW_KEY,         1'b0, 128'hffff0000_0000ffff_ffff0000_0000ffff},
    '{ROW_BLOCK,       1'b1, 128'h00000000_00000000_00000000_00000000},
    '{ROW_BLOCK,       1'b0, 128'h0f0f0f0f_f0f0f0f0_0f0f0f0f_f0f0f0f0},
    '{ROW_KEY,         1'b0, 128'h00000000_00000000_00000000_00000000},
    '{ROW_BLOCK,       1'b1, 128'hffffffff_ffffffff_ffffffff_ffffffff},
    '{ROW_BLOCK,       1'b0, 128'h00000000_00000000_00000000_00000000}
  };

  logic clk = 1'b0;
  logic rst_n;

  rsc_in_if  in_ch ();
  rsc_out_if out_ch ();
  rsc_cfg_if cfg_ch ();

  rabbit_stream_cipher u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Cipher state mirrored by the checker
  logic [WORD_W-1:0] ks_state [NUM_WORDS] = '{default: '0};
  logic [WORD_W-1:0] ks_ctr   [NUM_WORDS] = '{default: '0};
  logic              ks_carry   = 1'b0;
  logic [KEY_W-1:0]  key_low_q  = '0;
  logic [KEY_W-1:0]  key_high_q = '0;

  block_t cipher_due [$];
  block_t got_words;
  block_t want_words;
  int     mismatch_count = 0;
  int     quiet_cycles   = 0;
  bit     tx_no_gap      = 1'b0;
  bit     rx_no_stall    = 1'b0;

  function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] v, input int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  // Fold the 64-bit square: high half XOR low half
  function automatic logic [WORD_W-1:0] g_fold(input logic [WORD_W-1:0] v);
    logic [2*WORD_W-1:0] sq;
    sq = {32'd0, v} * {32'd0, v};
    return sq[63:32] ^ sq[31:0];
  endfunction

  // Advance one round: counter chain, g-function, state mix
  function automatic void next_round();
    logic [WORD_W:0]   sum;
    logic [WORD_W-1:0] g [NUM_WORDS];
    logic              cy;
    cy = ks_carry;
    for (int i = 0; i < NUM_WORDS; i++) begin
      sum       = {1'b0, ks_ctr[i]} + {1'b0, RATE_WORD[i]} + {{WORD_W{1'b0}}, cy};
      ks_ctr[i] = sum[WORD_W-1:0];
      cy        = sum[WORD_W];
    end
    ks_carry = cy;
    for (int i = 0; i < NUM_WORDS; i++)
      g[i] = g_fold(ks_state[i] + ks_ctr[i]);
    ks_state[0] = g[0] + rol(g[7], 16) + rol(g[6], 16);
    ks_state[1] = g[1] + rol(g[0], 8) + g[7];
    ks_state[2] = g[2] + rol(g[1], 16) + rol(g[0], 16);
    ks_state[3] = g[3] + rol(g[2], 8) + g[1];
    ks_state[4] = g[4] + rol(g[3], 16) + rol(g[2], 16);
    ks_state[5] = g[5] + rol(g[4], 8) + g[3];
    ks_state[6] = g[6] + rol(g[5], 16) + rol(g[4], 16);
    ks_state[7] = g[7] + rol(g[6], 8) + g[5];
  endfunction

  // Load state and counters from the key, run four rounds, fold state into counters
  function automatic void load_key();
    logic [WORD_W-1:0] k0, k1, k2, k3;
    k0 = key_low_q[31:0];
    k1 = key_low_q[63:32];
    k2 = key_high_q[31:0];
    k3 = key_high_q[63:32];
    ks_state[0] = k0;
    ks_state[2] = k1;
    ks_state[4] = k2;
    ks_state[6] = k3;
    ks_state[1] = {k3[15:0], k2[31:16]};
    ks_state[3] = {k0[15:0], k3[31:16]};
    ks_state[5] = {k1[15:0], k0[31:16]};
    ks_state[7] = {k2[15:0], k1[31:16]};
    ks_ctr[0] = rol(k2, 16);
    ks_ctr[2] = rol(k3, 16);
    ks_ctr[4] = rol(k0, 16);
    ks_ctr[6] = rol(k1, 16);
    ks_ctr[1] = {k0[31:16], k1[15:0]};
    ks_ctr[3] = {k1[31:16], k2[15:0]};
    ks_ctr[5] = {k2[31:16], k3[15:0]};
    ks_ctr[7] = {k3[31:16], k0[15:0]};
    ks_carry = 1'b0;
    repeat (SETUP_ROUNDS) next_round();
    for (int i = 0; i < NUM_WORDS; i++)
      ks_ctr[(i + 4) % NUM_WORDS] ^= ks_state[i];
  endfunction

  // Produce the ciphertext of one block and advance the cipher
  function automatic block_t cipher_block(input logic restart, input block_t data);
    block_t r;
    if (restart)
      load_key();
    next_round();
    r[0] = data[0] ^ ks_state[0] ^ (ks_state[5] >> 16) ^ (ks_state[3] << 16);
    r[1] = data[1] ^ ks_state[2] ^ (ks_state[7] >> 16) ^ (ks_state[5] << 16);
    r[2] = data[2] ^ ks_state[4] ^ (ks_state[1] >> 16) ^ (ks_state[7] << 16);
    r[3] = data[3] ^ ks_state[6] ^ (ks_state[3] >> 16) ^ (ks_state[1] << 16);
    return r;
  endfunction

  function automatic block_t random_words();
    block_t w;
    for (int i = 0; i < BLK_WORDS; i++) begin
      case ($urandom_range(0, 7))
        0:       w[i] = '0;
        1:       w[i] = '1;
        default: w[i] = $urandom();
      endcase
    end
    return w;
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Present one block after a random gap and hold it until the transfer
  task automatic send_block(input logic restart, input block_t data);
    int gap;
    gap = tx_no_gap ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.restart    <= restart;
    in_ch.data_word0 <= data[0];
    in_ch.data_word1 <= data[1];
    in_ch.data_word2 <= data[2];
    in_ch.data_word3 <= data[3];
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stop sending and hold until every pending block has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (cipher_due.size() != 0);
  endtask

  // Leaves valid high; the caller drops it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // Result side: stall a random number of cycles per block, then take it
  initial begin
    int stall;
    forever begin
      stall = rx_no_stall ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Track config writes, predict accepted blocks, check results, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          rsc_pkg::REG_KEY_LOW:  key_low_q  = cfg_ch.data;
          rsc_pkg::REG_KEY_HIGH: key_high_q = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        cipher_due.push_back(cipher_block(in_ch.restart, {in_ch.data_word3,
            in_ch.data_word2, in_ch.data_word1, in_ch.data_word0}));
      if (out_ch.valid && out_ch.ready) begin
        got_words = {out_ch.out_word3, out_ch.out_word2, out_ch.out_word1, out_ch.out_word0};
        if (cipher_due.size() == 0) begin
          $error("out transfer with no block pending: %032h", got_words);
          mismatch_count++;
        end else begin
          want_words = cipher_due.pop_front();
          for (int i = 0; i < BLK_WORDS; i++) begin
            if (got_words[i] !== want_words[i]) begin
              $error("out_word%0d: expected %08h, actual %08h", i, want_words[i], got_words[i]);
              mismatch_count++;
            end
          end
        end
      end
      if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
          (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("rabbit_stream_cipher test failed");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, then random phases with key changes between them
  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.restart    <= 1'b0;
    in_ch.data_word0 <= '0;
    in_ch.data_word1 <= '0;
    in_ch.data_word2 <= '0;
    in_ch.data_word3 <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= rsc_pkg::REG_KEY_LOW;
    cfg_ch.data      <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      case (STIM_TABLE[r].kind)
        ROW_BLOCK: send_block(STIM_TABLE[r].restart, STIM_TABLE[r].words);
        ROW_KEY: begin
          wait_for_results();
          write_reg(rsc_pkg::REG_KEY_LOW,
                    {STIM_TABLE[r].words[1], STIM_TABLE[r].words[0]});
          write_reg(rsc_pkg::REG_KEY_HIGH,
                    {STIM_TABLE[r].words[3], STIM_TABLE[r].words[2]});
          cfg_ch.valid <= 1'b0;
        end
        default: begin
          wait_for_results();
          write_reg(REG_SPARE_2, {STIM_TABLE[r].words[1], STIM_TABLE[r].words[0]});
          write_reg(REG_SPARE_3, {STIM_TABLE[r].words[3], STIM_TABLE[r].words[2]});
          cfg_ch.valid <= 1'b0;
        end
      endcase
    end

    // Random phases: mostly restart then a long stream, with stray restarts
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_for_results();
      if ($urandom_range(0, 3) != 0)
        write_reg(rsc_pkg::REG_KEY_LOW, random_key());
      if ($urandom_range(0, 3) != 0)
        write_reg(rsc_pkg::REG_KEY_HIGH, random_key());
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, random_key());
      cfg_ch.valid <= 1'b0;
      tx_no_gap   = ($urandom_range(0, 3) == 0);
      rx_no_stall = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        send_block((n == 0 && p % 4 != 3) || $urandom_range(0, 15) == 0, random_words());
        if (p == 2 && n == BLOCKS_PER_PHASE / 2)
          wait_for_results();
        if ($urandom_range(0, 31) == 0)
          tx_no_gap = !tx_no_gap;
        if ($urandom_range(0, 31) == 0)
          rx_no_stall = !rx_no_stall;
      end
    end

    // Drain and let the block settle
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("rabbit_stream_cipher test passed");
    else
      $display("rabbit_stream_cipher test failed");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/rsc_pkg.sv
rtl/core/rsc_ifs.sv
rtl/core/rsc_datapath.sv
rtl/core/rsc_ctrl.sv
rtl/core/rabbit_stream_cipher.sv
verif/testbench.sv
